// ----- rtl/core/wht_pkg.sv -----
// Shared types, constants and the arctangent table of the waypoint heading tracker.
package wht_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Angles are Q.24 radians
    localparam int ANG_W = 29;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 29'sd105414357;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 29'sd26353589;
    localparam logic [23:0]             CORDIC_K    = 24'd10188014;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_POSE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REACH_TOL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 3'd5;

    typedef enum logic [1:0] {
        EV_DRIVE   = 2'd0,
        EV_REACHED = 2'd1,
        EV_TIMEOUT = 2'd2,
        EV_FINISH  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        JOB_CLEAR,
        JOB_APPEND,
        JOB_POSE
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] yaw;
    } job_t;

    typedef struct packed {
        logic [30:0] reach_tol;
        logic [14:0] fwd_limit;
        logic [15:0] gain;
        logic [14:0] turn_limit;
        logic [15:0] timeout;
        logic [15:0] tick_limit;
    } cfg_t;

    function automatic logic [23:0] atan_lut(input logic [4:0] i);
        logic [23:0] v;
        case (i)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/wht_if.sv -----
// Valid/ready channel interfaces for pose/waypoint items and tracker results.
interface wht_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;

    modport source (output valid, mode, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, mode, pos_x, pos_y, heading, output ready);
endinterface

interface wht_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_res;
    logic [14:0]        forward_speed;
    logic signed [15:0] turn_rate;
    logic [8:0]         target_index;
    logic [8:0]         reached_total;

    modport source (output valid, event_res, forward_speed, turn_rate, target_index,
                    reached_total, input ready);
    modport sink   (input valid, event_res, forward_speed, turn_rate, target_index,
                    reached_total, output ready);
endinterface

// ----- rtl/core/wht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/wht_front.sv -----
// Front end: takes input transfers, classifies them, drops no-ops and queues jobs.
module wht_front #(
    parameter int MAX_WAYPOINTS = wht_pkg::MAX_WAYPOINTS_DEF,
    localparam int LW           = $clog2(MAX_WAYPOINTS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    wht_in_if.sink         in_ch,
    output logic           job_valid,
    input  logic           job_ready,
    output wht_pkg::job_t  job,
    output logic [LW-1:0]  job_len
);

    // two-entry job queue
    wht_pkg::job_t q_job_reg [2];
    logic [LW-1:0] q_len_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [LW-1:0] len_reg, len_next;

    logic          take;
    logic          keep;
    logic          push;
    logic          pop;
    wht_pkg::job_t new_job;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign take        = in_ch.valid && in_ch.ready;
    assign job_valid   = (cnt_reg != 2'd0);
    assign pop         = job_valid && job_ready;
    assign job         = q_job_reg[rd_ptr_reg];
    assign job_len     = q_len_reg[rd_ptr_reg];

    always_comb
    begin
        new_job.x   = in_ch.pos_x;
        new_job.y   = in_ch.pos_y;
        new_job.yaw = in_ch.heading;
        len_next    = len_reg;
        case (in_ch.mode)
            wht_pkg::MODE_CLEAR:
            begin
                new_job.kind = wht_pkg::JOB_CLEAR;
                keep         = 1'b1;
                if (take)
                begin
                    len_next = '0;
                end
            end
            wht_pkg::MODE_APPEND:
            begin
                new_job.kind = wht_pkg::JOB_APPEND;
                // appends past capacity are dropped here
                keep         = (len_reg < LW'(MAX_WAYPOINTS));
                if (take && keep)
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            wht_pkg::MODE_POSE:
            begin
                new_job.kind = wht_pkg::JOB_POSE;
                keep         = 1'b1;
            end
            default:
            begin
                new_job.kind = wht_pkg::JOB_POSE;
                keep         = 1'b0;
            end
        endcase
    end

    assign push        = take && keep;
    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            len_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
        end
    end

    // length tag: write address for appends, path length for pose ticks
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_job_reg[wr_ptr_reg] <= new_job;
            q_len_reg[wr_ptr_reg] <= len_reg;
        end
    end

endmodule

// ----- rtl/core/wht_back.sv -----
// Back end: executes queued jobs, runs the vectoring and cosine CORDIC, holds the result.
module wht_back #(
    parameter int MAX_WAYPOINTS = wht_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wht_pkg::CORDIC_STEPS_DEF,
    localparam int LW           = $clog2(MAX_WAYPOINTS + 1),
    localparam int AW           = $clog2(MAX_WAYPOINTS),
    localparam int IW           = $clog2(CORDIC_STEPS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wht_pkg::cfg_t  cfg,
    input  logic           job_valid,
    output logic           job_ready,
    input  wht_pkg::job_t  job,
    input  logic [LW-1:0]  job_len,
    output logic           ram_we,
    output logic [AW-1:0]  ram_waddr,
    output logic [63:0]    ram_wdata,
    output logic [AW-1:0]  ram_raddr,
    input  logic [63:0]    ram_rdata,
    wht_out_if.source      out_ch
);

    localparam int XW = 36;
    localparam int CW = 27;
    localparam int AN = wht_pkg::ANG_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_VEC,
        S_MAG0,
        S_MAG1,
        S_MAG2,
        S_DECIDE,
        S_COS,
        S_MULT,
        S_EMIT
    } state_t;

    state_t state_reg;

    // tracking state
    logic [LW-1:0]  tgt_reg;
    logic [LW-1:0]  reached_reg;
    logic [15:0]    tot_reg;
    logic [15:0]    ttl_reg;
    logic           fin_reg;

    // working registers
    logic signed [31:0]   px_reg, py_reg;
    logic signed [15:0]   yaw_reg;
    logic [IW-1:0]        it_reg;
    logic signed [XW-1:0] vx_reg, vy_reg;
    logic signed [AN-1:0] z_reg;
    logic [41:0]          prod_lo_reg;
    logic [40:0]          prod_hi_reg;
    logic [34:0]          mag_reg;
    logic [27:0]          abs_reg;
    logic                 neg_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [AN-1:0] cz_reg;
    logic [24:0]          cos_reg;
    wht_pkg::event_t      ev_reg;
    logic [14:0]          fwd_reg;
    logic signed [15:0]   turn_reg;

    // output register
    logic               out_valid_reg;
    wht_pkg::event_t    o_ev_reg;
    logic [14:0]        o_fwd_reg;
    logic signed [15:0] o_turn_reg;
    logic [8:0]         o_tgt_reg;
    logic [8:0]         o_rch_reg;

    logic signed [32:0]   dx_c, dy_c;
    logic signed [XW-1:0] dxe_c, dye_c;
    logic signed [AN-1:0] at_c;
    logic [34:0]          xu_c;
    logic [59:0]          sum_c;
    logic signed [AN-1:0] yt_c, e0_c, ew_c;
    logic [27:0]          ea_c;
    logic [27:0]          base28_c;
    logic [14:0]          base_c;
    logic [39:0]          fprod_c;
    logic [43:0]          tprod_c;
    logic [19:0]          tm_c;
    logic [14:0]          tmc_c;
    logic                 pose_stop_c;
    logic                 out_free_c;
    logic                 last_it_c;

    assign job_ready  = (state_reg == S_IDLE);
    assign ram_we     = (state_reg == S_IDLE) && job_valid && (job.kind == wht_pkg::JOB_APPEND);
    assign ram_waddr  = job_len[AW-1:0];
    assign ram_wdata  = {job.x, job.y};
    assign ram_raddr  = tgt_reg[AW-1:0];
    assign out_free_c = !out_valid_reg || out_ch.ready;
    assign last_it_c  = (it_reg == IW'(CORDIC_STEPS - 1));

    always_comb
    begin
        pose_stop_c = fin_reg || (ttl_reg >= cfg.tick_limit) || (job_len < LW'(2))
                      || (tgt_reg >= job_len);
        dx_c  = {ram_rdata[63], ram_rdata[63:32]} - {px_reg[31], px_reg};
        dy_c  = {ram_rdata[31], ram_rdata[31:0]} - {py_reg[31], py_reg};
        dxe_c = XW'(dx_c);
        dye_c = XW'(dy_c);
        at_c  = $signed({5'd0, wht_pkg::atan_lut(5'(it_reg))});
        xu_c  = vx_reg[XW-1] ? '0 : vx_reg[34:0];
        sum_c = 60'(prod_lo_reg) + (60'(prod_hi_reg) << 18) + 60'(24'h800000);
        yt_c  = {{2{yaw_reg[15]}}, yaw_reg, 11'd0};
        e0_c  = z_reg - yt_c;
        // one wrap suffices for the reachable range of the error
        if (e0_c > wht_pkg::ANG_PI)
        begin
            ew_c = e0_c - wht_pkg::ANG_TWO_PI;
        end
        else if (e0_c < -wht_pkg::ANG_PI)
        begin
            ew_c = e0_c + wht_pkg::ANG_TWO_PI;
        end
        else
        begin
            ew_c = e0_c;
        end
        ea_c     = ew_c[AN-1] ? 28'(-ew_c) : ew_c[27:0];
        base28_c = mag_reg[34:7];
        base_c   = (base28_c > 28'(cfg.fwd_limit)) ? cfg.fwd_limit : base28_c[14:0];
        fprod_c  = base_c * cos_reg;
        tprod_c  = cfg.gain * abs_reg;
        tm_c     = tprod_c[43:24];
        tmc_c    = (tm_c > 20'(cfg.turn_limit)) ? cfg.turn_limit : tm_c[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tgt_reg       <= LW'(1);
            reached_reg   <= '0;
            tot_reg       <= '0;
            ttl_reg       <= '0;
            fin_reg       <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            yaw_reg       <= '0;
            it_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            z_reg         <= '0;
            prod_lo_reg   <= '0;
            prod_hi_reg   <= '0;
            mag_reg       <= '0;
            abs_reg       <= '0;
            neg_reg       <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            cos_reg       <= '0;
            ev_reg        <= wht_pkg::EV_DRIVE;
            fwd_reg       <= '0;
            turn_reg      <= '0;
            out_valid_reg <= 1'b0;
            o_ev_reg      <= wht_pkg::EV_DRIVE;
            o_fwd_reg     <= '0;
            o_turn_reg    <= '0;
            o_tgt_reg     <= '0;
            o_rch_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        case (job.kind)
                            wht_pkg::JOB_CLEAR:
                            begin
                                tgt_reg     <= LW'(1);
                                reached_reg <= '0;
                                tot_reg     <= '0;
                                ttl_reg     <= '0;
                                fin_reg     <= 1'b0;
                            end
                            wht_pkg::JOB_POSE:
                            begin
                                fwd_reg  <= '0;
                                turn_reg <= '0;
                                px_reg   <= job.x;
                                py_reg   <= job.y;
                                yaw_reg  <= job.yaw;
                                if (pose_stop_c)
                                begin
                                    fin_reg   <= 1'b1;
                                    ev_reg    <= wht_pkg::EV_FINISH;
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    // waypoint read issued this cycle at tgt_reg
                                    ttl_reg   <= ttl_reg + 16'd1;
                                    state_reg <= S_LOAD;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_LOAD:
                begin
                    it_reg <= '0;
                    if (dx_c == '0 && dy_c == '0)
                    begin
                        z_reg     <= '0;
                        mag_reg   <= '0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        // fold into the right half plane
                        if (dx_c[32])
                        begin
                            vx_reg <= -dxe_c;
                            vy_reg <= -dye_c;
                            z_reg  <= dy_c[32] ? -wht_pkg::ANG_PI : wht_pkg::ANG_PI;
                        end
                        else
                        begin
                            vx_reg <= dxe_c;
                            vy_reg <= dye_c;
                            z_reg  <= '0;
                        end
                        state_reg <= S_VEC;
                    end
                end
                S_VEC:
                begin
                    if (!vy_reg[XW-1] && vy_reg != '0)
                    begin
                        vx_reg <= vx_reg + (vy_reg >>> it_reg);
                        vy_reg <= vy_reg - (vx_reg >>> it_reg);
                        z_reg  <= z_reg + at_c;
                    end
                    else
                    begin
                        vx_reg <= vx_reg - (vy_reg >>> it_reg);
                        vy_reg <= vy_reg + (vx_reg >>> it_reg);
                        z_reg  <= z_reg - at_c;
                    end
                    it_reg <= it_reg + 1'b1;
                    if (last_it_c)
                    begin
                        state_reg <= S_MAG0;
                    end
                end
                S_MAG0:
                begin
                    prod_lo_reg <= xu_c[17:0] * wht_pkg::CORDIC_K;
                    state_reg   <= S_MAG1;
                end
                S_MAG1:
                begin
                    prod_hi_reg <= xu_c[34:18] * wht_pkg::CORDIC_K;
                    state_reg   <= S_MAG2;
                end
                S_MAG2:
                begin
                    mag_reg   <= sum_c[58:24];
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (tot_reg >= cfg.timeout)
                    begin
                        ev_reg    <= wht_pkg::EV_TIMEOUT;
                        tgt_reg   <= tgt_reg + 1'b1;
                        tot_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (mag_reg < 35'(cfg.reach_tol))
                    begin
                        ev_reg      <= wht_pkg::EV_REACHED;
                        reached_reg <= reached_reg + 1'b1;
                        tgt_reg     <= tgt_reg + 1'b1;
                        tot_reg     <= '0;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        ev_reg  <= wht_pkg::EV_DRIVE;
                        abs_reg <= ea_c;
                        neg_reg <= ew_c[AN-1];
                        if (tot_reg != 16'hFFFF)
                        begin
                            tot_reg <= tot_reg + 16'd1;
                        end
                        it_reg <= '0;
                        if (ea_c < 28'(wht_pkg::ANG_HALF_PI))
                        begin
                            cx_reg    <= $signed(CW'(wht_pkg::CORDIC_K));
                            cy_reg    <= '0;
                            cz_reg    <= $signed({1'b0, ea_c});
                            state_reg <= S_COS;
                        end
                        else
                        begin
                            cos_reg   <= '0;
                            state_reg <= S_MULT;
                        end
                    end
                end
                S_COS:
                begin
                    if (!cz_reg[AN-1])
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> it_reg);
                        cy_reg <= cy_reg + (cx_reg >>> it_reg);
                        cz_reg <= cz_reg - at_c;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> it_reg);
                        cy_reg <= cy_reg - (cx_reg >>> it_reg);
                        cz_reg <= cz_reg + at_c;
                    end
                    it_reg <= it_reg + 1'b1;
                    if (last_it_c)
                    begin
                        state_reg <= S_MULT;
                    end
                end
                S_MULT:
                begin
                    // cx_reg now holds the finished cosine; clamp to [0, 1.0]
                    if (cos_reg == '0 && cx_reg != '0 && !cx_reg[CW-1])
                    begin
                        cos_reg <= (cx_reg[25:0] > 26'h1000000) ? 25'h1000000 : cx_reg[24:0];
                        cx_reg  <= '0;
                    end
                    else
                    begin
                        fwd_reg   <= fprod_c[38:24];
                        turn_reg  <= neg_reg ? -$signed({1'b0, tmc_c}) : $signed({1'b0, tmc_c});
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free_c)
                    begin
                        out_valid_reg <= 1'b1;
                        o_ev_reg      <= ev_reg;
                        o_fwd_reg     <= fwd_reg;
                        o_turn_reg    <= turn_reg;
                        o_tgt_reg     <= 9'(tgt_reg);
                        o_rch_reg     <= 9'(reached_reg);
                        cos_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.event_res     = o_ev_reg;
    assign out_ch.forward_speed = o_fwd_reg;
    assign out_ch.turn_rate     = o_turn_reg;
    assign out_ch.target_index  = o_tgt_reg;
    assign out_ch.reached_total = o_rch_reg;

`ifndef NO_ASSERTIONS
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VEC || state_reg == S_COS) |-> (it_reg < IW'(CORDIC_STEPS)))
        else $error("CORDIC iteration counter out of range");

    a_reached_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        reached_reg < tgt_reg)
        else $error("reached count caught up with target index");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit state");

    a_no_job_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> !ram_we || $past(state_reg == S_EMIT))
        else $error("path store written while a pose tick is in flight");
`endif

endmodule

// ----- rtl/core/waypoint_heading_tracker_top.sv -----
// Top level of the waypoint heading tracker: configuration registers and block wiring.
//
// Usage:
//   in_ch carries items: mode 0 clears the path, 1 appends a waypoint (pos_x, pos_y),
//   2 is a pose tick (robot pos_x, pos_y, heading); mode 3 is dropped.
//   out_ch carries one result per pose tick: event, forward speed, turn rate,
//   target index and reached count. Clears and appends give no result.
//   cfg_we/cfg_index/cfg_data write a register; write only while idle.
// Timing:
//   A two-entry job queue sits behind in_ch, so the input side keeps taking
//   transfers while the back end works. The back end does a clear or append in
//   its idle state. A driving pose tick runs a vectoring CORDIC for distance
//   and bearing, then, when the heading error is below pi/2, a rotation CORDIC
//   for the cosine, both iterating one step a cycle on a shared sequencer. Reached,
//   timed-out and finished ticks are shorter. One pose tick is worked at a time.
// Reset: path empty, tracking restarts at entry 1, registers take their defaults.
//   The path store itself is not cleared; only written entries are ever read.
// Stall: a result waits in the output register while out_ch.ready is low; the
//   back end then holds in its emit state and the queue fills before in_ch stalls.
module waypoint_heading_tracker_top #(
    parameter int MAX_WAYPOINTS = wht_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wht_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    wht_in_if.sink                         in_ch,
    wht_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [wht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wht_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_WAYPOINTS + 1);
    localparam int AW = $clog2(MAX_WAYPOINTS);

    wht_pkg::cfg_t cfg_reg;
    wht_pkg::job_t job;
    logic [LW-1:0] job_len;
    logic          job_valid;
    logic          job_ready;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reach_tol  <= 31'd19661;
            cfg_reg.fwd_limit  <= 15'd128;
            cfg_reg.gain       <= 16'd256;
            cfg_reg.turn_limit <= 15'd256;
            cfg_reg.timeout    <= 16'd300;
            cfg_reg.tick_limit <= 16'd5000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wht_pkg::REG_REACH_TOL:  cfg_reg.reach_tol  <= cfg_data[30:0];
                wht_pkg::REG_FWD_LIMIT:  cfg_reg.fwd_limit  <= cfg_data[14:0];
                wht_pkg::REG_GAIN:       cfg_reg.gain       <= cfg_data[15:0];
                wht_pkg::REG_TURN_LIMIT: cfg_reg.turn_limit <= cfg_data[14:0];
                wht_pkg::REG_TIMEOUT:    cfg_reg.timeout    <= cfg_data[15:0];
                wht_pkg::REG_TICK_LIMIT: cfg_reg.tick_limit <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    wht_front #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .job_len   (job_len)
    );

    wht_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WAYPOINTS)
    ) u_path (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wht_back #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .job_len   (job_len),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_ch    (out_ch)
    );

endmodule
